### src/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared types for the reversible deque
// Holds the command codes, the result status codes and the result bundle
// that the pointer control hands to the top level.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int unsigned DataW = 32;

	typedef enum logic [2:0] {
		KIND_POP_BACK   = 3'd0,
		KIND_POP_FRONT  = 3'd1,
		KIND_REVERSE    = 3'd2,
		KIND_PUSH_BACK  = 3'd3,
		KIND_PUSH_FRONT = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Result word bookkeeping: strobe and status of the word in flight
	typedef struct packed {
		logic    done;
		status_t status;
	} res_t;

endpackage

### src/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram: element store
// Single-port synchronous memory, one write or one read per cycle, with the
// read data registered. Contents are not cleared at reset.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic                                 re,
	input  logic [AW-1:0]                        addr,
	input  logic signed [deq_pkg::DataW-1:0]     wdata,
	output logic signed [deq_pkg::DataW-1:0]     rdata
);

	logic signed [deq_pkg::DataW-1:0] mem [DEPTH];
	logic signed [deq_pkg::DataW-1:0] rdata_q;

	// Write the pushed word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// Register the popped word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl: end pointers, fill count and direction flag
// Decodes one command per cycle, moves the proper physical end and issues
// the store access. Results leave in the next cycle, aligned with read data.
// ----------------------------------------------------------------------------
module deq_ctrl #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10,
	parameter int unsigned CW    = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic [2:0]                        kind,
	input  logic signed [deq_pkg::DataW-1:0]  value,
	output logic                              mem_we,
	output logic                              mem_re,
	output logic [AW-1:0]                     mem_addr,
	output logic signed [deq_pkg::DataW-1:0]  mem_wdata,
	output deq_pkg::res_t                     res
);

	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic          rev_q;
	deq_pkg::res_t res_q;

	logic [AW-1:0] head_d, tail_d;
	logic [CW-1:0] count_d;
	logic          rev_d;
	deq_pkg::res_t res_d;
	logic          phys_back;
	logic          is_empty, is_full;
	logic [AW-1:0] head_next, head_prev, tail_next, tail_prev;

	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == FullCnt);
	assign head_next = (head_q == LastIdx) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? LastIdx : head_q - 1'b1;
	assign tail_next = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LastIdx : tail_q - 1'b1;

	// Logical back maps to the physical back unless reversed
	assign phys_back = ((kind == deq_pkg::KIND_POP_BACK) ||
		(kind == deq_pkg::KIND_PUSH_BACK)) ^ rev_q;

	// Decode the command, move the end and drive the store access
	always_comb begin
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		rev_d       = rev_q;
		res_d.done  = 1'b0;
		res_d.status = deq_pkg::STATUS_OK;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_addr    = head_q;
		mem_wdata   = value;
		if (take) begin
			case (kind)
				deq_pkg::KIND_POP_BACK, deq_pkg::KIND_POP_FRONT: begin
					res_d.done = 1'b1;
					if (is_empty) begin
						res_d.status = deq_pkg::STATUS_EMPTY;
					end else begin
						mem_re  = 1'b1;
						count_d = count_q - 1'b1;
						if (phys_back) begin
							mem_addr = head_q;
							head_d   = head_next;
						end else begin
							mem_addr = tail_prev;
							tail_d   = tail_prev;
						end
					end
				end
				deq_pkg::KIND_REVERSE: begin
					rev_d = ~rev_q;
				end
				deq_pkg::KIND_PUSH_BACK, deq_pkg::KIND_PUSH_FRONT: begin
					if (is_full) begin
						res_d.done   = 1'b1;
						res_d.status = deq_pkg::STATUS_FULL;
					end else begin
						mem_we  = 1'b1;
						count_d = count_q + 1'b1;
						if (phys_back) begin
							mem_addr = head_prev;
							head_d   = head_prev;
						end else begin
							mem_addr = tail_q;
							tail_d   = tail_next;
						end
					end
				end
				default: begin
					// unused codes: drop
				end
			endcase
		end
	end

	// Hold pointers, fill count, flag and the result strobe and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
			res_q   <= '{done: 1'b0, status: deq_pkg::STATUS_OK};
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			rev_q   <= rev_d;
			res_q   <= res_d;
		end
	end

	assign res = res_q;

	// Fill count stays within the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FullCnt)
		else $error("fill count above depth");

	// Empty or full store has coinciding ends
	a_ends_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(is_empty || is_full) |-> (head_q == tail_q))
		else $error("ends disagree with fill count");

	// Every pop gives a result word next cycle
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && ((kind == deq_pkg::KIND_POP_BACK) ||
		(kind == deq_pkg::KIND_POP_FRONT))) |=> res_q.done)
		else $error("pop without result");

	// A push that fits gives no result and grows the count
	a_push_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !is_full && ((kind == deq_pkg::KIND_PUSH_BACK) ||
		(kind == deq_pkg::KIND_PUSH_FRONT))) |=>
		(!res_q.done && (count_q == $past(count_q) + 1'b1)))
		else $error("accepted push misbehaved");

endmodule

### src/reversible_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reversible_deque: double-ended queue of signed words with a reverse flag
// A pop, or a push into a full store, strobes done in the cycle after
// start. Throughput: one command per cycle; busy stays low, since each
// command takes a single access on the one store port. The receiver cannot
// stall. Reset clears the ends, fill count and reverse flag at once; the
// store contents are left as they are and only written entries are read.
// ----------------------------------------------------------------------------
module reversible_deque #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        kind,
	input  logic signed [deq_pkg::DataW-1:0]  value,
	output logic                              done,
	output logic signed [deq_pkg::DataW-1:0]  value_res,
	output logic [1:0]                        status
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic                             mem_we, mem_re;
	logic [AW-1:0]                    mem_addr;
	logic signed [deq_pkg::DataW-1:0] mem_wdata, mem_rdata;
	deq_pkg::res_t                    res;

	// Every command completes its store access in its own cycle
	assign busy = 1'b0;

	deq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (start && !busy),
		.kind      (kind),
		.value     (value),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.res       (res)
	);

	deq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Drive the result word; zero the value on an empty or full status
	assign done      = res.done;
	assign status    = res.status;
	assign value_res = (res.status == deq_pkg::STATUS_OK) ? mem_rdata : '0;

endmodule
